// ===== src/swc_pkg.sv =====
package swc_pkg;

  // Field widths
  localparam int HOUR_BITS  = 8;
  localparam int TICK_W     = 8;
  localparam int DEB_W      = 8;
  localparam int TIMER_W    = 16;
  localparam int HUND_W     = 7;
  localparam int SEC_W      = 6;
  localparam int MIN_W      = 6;
  localparam int MODE_W     = 2;
  localparam int EV_W       = 2;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 4;

  // Wrap points of the time digits
  localparam logic [HUND_W:0] HUND_WRAP = 8'd100;
  localparam logic [SEC_W:0]  SEC_WRAP  = 7'd60;
  localparam logic [MIN_W:0]  MIN_WRAP  = 7'd60;

  // Classified press events
  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

  // Stopwatch modes
  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_TICKS_PER_HUND = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE       = 2'd1;
  localparam logic [1:0] REG_LONG_HOLD      = 2'd2;
  localparam logic [1:0] REG_BEEP_HUND      = 2'd3;

  // Register reset values
  localparam logic [TICK_W-1:0]  RST_TICKS_PER_HUND = 8'd2;
  localparam logic [DEB_W-1:0]   RST_DEBOUNCE       = 8'd10;
  localparam logic [TIMER_W-1:0] RST_LONG_HOLD      = 16'd200;
  localparam logic [HUND_W-1:0]  RST_BEEP_HUND      = 7'd10;

endpackage

// ===== src/swc_button.sv =====
module swc_button (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic                              level,
  input  logic [swc_pkg::DEB_W-1:0]         debounce_ticks,
  input  logic [swc_pkg::TIMER_W-1:0]       long_hold_ticks,
  output logic [swc_pkg::EV_W-1:0]          press_event
);

  typedef enum logic [2:0] {
    PH_READY     = 3'd0,
    PH_DEB_PRESS = 3'd1,
    PH_WAIT_REL  = 3'd2,
    PH_WAIT_LONG = 3'd3,
    PH_DEB_REL   = 3'd4
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [swc_pkg::TIMER_W-1:0]    timer_r, timer_nxt;
  logic                           long_r, long_nxt;
  logic [swc_pkg::TIMER_W-1:0]    deb_load;

  assign deb_load = {{(swc_pkg::TIMER_W-swc_pkg::DEB_W){1'b0}}, debounce_ticks};

  // Press classifier: debounce, hold timing, release debounce
  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    long_nxt    = long_r;
    press_event = swc_pkg::EV_NONE;
    case (phase_r)
      PH_READY: begin
        if (level) begin
          timer_nxt = deb_load;
          phase_nxt = PH_DEB_PRESS;
        end
      end
      PH_DEB_PRESS: begin
        if (timer_r == '0) begin
          timer_nxt = long_hold_ticks;
          phase_nxt = PH_WAIT_REL;
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      PH_WAIT_REL: begin
        if (!level) begin
          timer_nxt = deb_load;
          phase_nxt = PH_DEB_REL;
        end else if (timer_r != '0) begin
          timer_nxt = timer_r - 1'b1;
        end else begin
          phase_nxt = PH_WAIT_LONG;
        end
      end
      PH_WAIT_LONG: begin
        if (!level) begin
          long_nxt  = 1'b1;
          timer_nxt = deb_load;
          phase_nxt = PH_DEB_REL;
        end
      end
      PH_DEB_REL: begin
        if (timer_r == '0) begin
          press_event = long_r ? swc_pkg::EV_LONG : swc_pkg::EV_SHORT;
          long_nxt    = 1'b0;
          phase_nxt   = PH_READY;
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_READY;
        timer_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_READY;
      timer_r <= '0;
      long_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      long_r  <= long_nxt;
    end
  end

  // A long press is only flagged once the hold wait has run out
  a_long_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step && !long_r && long_nxt |-> phase_r == PH_WAIT_LONG)
    else $error("long flag set outside long hold wait");

  // Any event leaves the classifier ready with the long flag cleared
  a_event_ready: assert property (@(posedge clk) disable iff (!rst_n)
    step && press_event != swc_pkg::EV_NONE |=> phase_r == PH_READY && !long_r)
    else $error("classifier not ready after event");

  // Debounce of a press ignores the level
  a_deb_press: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_DEB_PRESS && timer_r != '0 |=> phase_r == PH_DEB_PRESS)
    else $error("press debounce left early");

endmodule

// ===== src/stopwatch_controller_core.sv =====
// Stopwatch controller. Each input transfer is one base tick carrying the
// button level; each tick yields exactly one result transfer holding the mode,
// the elapsed time, the beep flag and the press classified on that tick. A new
// tick can be taken every clock cycle, and its result is in the output
// register in the cycle after the tick. A new tick is taken in the same cycle
// that the waiting result is taken. Only a stalled, full output register
// holds off the input. The four registers (ticks per hundredth, debounce
// ticks, long hold ticks, beep hundredth) sit at byte addresses 0, 4, 8 and
// 12; the user must write them only while the block is idle, which the block
// does not enforce. No clearing pass is needed after reset.
module stopwatch_controller_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_button_level,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [swc_pkg::MODE_W-1:0]        out_mode,
  output logic [swc_pkg::HOUR_BITS-1:0]     out_hours,
  output logic [swc_pkg::MIN_W-1:0]         out_minutes,
  output logic [swc_pkg::SEC_W-1:0]         out_seconds,
  output logic [swc_pkg::HUND_W-1:0]        out_hundredths,
  output logic                              out_beep_on,
  output logic [swc_pkg::EV_W-1:0]          out_press_event,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swc_pkg::APB_AW-1:0]        paddr,
  input  logic [swc_pkg::APB_DW-1:0]        pwdata,
  output logic [swc_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  logic [swc_pkg::TICK_W-1:0]     tph_r;
  logic [swc_pkg::DEB_W-1:0]      deb_r;
  logic [swc_pkg::TIMER_W-1:0]    hold_r;
  logic [swc_pkg::HUND_W-1:0]     beep_hund_r;

  logic [swc_pkg::MODE_W-1:0]     mode_r, mode_nxt;
  logic [swc_pkg::TICK_W-1:0]     pre_r, pre_nxt;
  logic [swc_pkg::HUND_W-1:0]     hund_r, hund_nxt;
  logic [swc_pkg::SEC_W-1:0]      sec_r, sec_nxt;
  logic [swc_pkg::MIN_W-1:0]      min_r, min_nxt;
  logic [swc_pkg::HOUR_BITS-1:0]  hour_r, hour_nxt;
  logic                           beep_r, beep_nxt;

  logic                           res_valid_r;
  logic [swc_pkg::MODE_W-1:0]     res_mode_r;
  logic [swc_pkg::HOUR_BITS-1:0]  res_hour_r;
  logic [swc_pkg::MIN_W-1:0]      res_min_r;
  logic [swc_pkg::SEC_W-1:0]      res_sec_r;
  logic [swc_pkg::HUND_W-1:0]     res_hund_r;
  logic                           res_beep_r;
  logic [swc_pkg::EV_W-1:0]       res_ev_r;

  logic                           accept;
  logic                           cfg_wr;
  logic [1:0]                     reg_idx;
  logic [swc_pkg::EV_W-1:0]       ev;
  logic [swc_pkg::TICK_W:0]       pre_inc;
  logic [swc_pkg::HUND_W:0]       hund_inc;
  logic [swc_pkg::SEC_W:0]        sec_inc;
  logic [swc_pkg::MIN_W:0]        min_inc;

  assign in_stall = res_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tph_r       <= swc_pkg::RST_TICKS_PER_HUND;
      deb_r       <= swc_pkg::RST_DEBOUNCE;
      hold_r      <= swc_pkg::RST_LONG_HOLD;
      beep_hund_r <= swc_pkg::RST_BEEP_HUND;
    end else if (cfg_wr) begin
      case (reg_idx)
        swc_pkg::REG_TICKS_PER_HUND: tph_r       <= pwdata[swc_pkg::TICK_W-1:0];
        swc_pkg::REG_DEBOUNCE:       deb_r       <= pwdata[swc_pkg::DEB_W-1:0];
        swc_pkg::REG_LONG_HOLD:      hold_r      <= pwdata[swc_pkg::TIMER_W-1:0];
        swc_pkg::REG_BEEP_HUND:      beep_hund_r <= pwdata[swc_pkg::HUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swc_pkg::REG_TICKS_PER_HUND:
        prdata = {{(swc_pkg::APB_DW-swc_pkg::TICK_W){1'b0}}, tph_r};
      swc_pkg::REG_DEBOUNCE:
        prdata = {{(swc_pkg::APB_DW-swc_pkg::DEB_W){1'b0}}, deb_r};
      swc_pkg::REG_LONG_HOLD:
        prdata = {{(swc_pkg::APB_DW-swc_pkg::TIMER_W){1'b0}}, hold_r};
      swc_pkg::REG_BEEP_HUND:
        prdata = {{(swc_pkg::APB_DW-swc_pkg::HUND_W){1'b0}}, beep_hund_r};
      default: prdata = '0;
    endcase
  end

  // Press classifier
  swc_button u_button (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (accept),
    .level           (in_button_level),
    .debounce_ticks  (deb_r),
    .long_hold_ticks (hold_r),
    .press_event     (ev)
  );

  assign pre_inc  = {1'b0, pre_r} + 1'b1;
  assign hund_inc = {1'b0, hund_r} + 1'b1;
  assign sec_inc  = {1'b0, sec_r} + 1'b1;
  assign min_inc  = {1'b0, min_r} + 1'b1;

  // Time count with the mode at the start of the tick, then the mode update
  always_comb begin
    pre_nxt  = pre_r;
    hund_nxt = hund_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    beep_nxt = beep_r;
    mode_nxt = mode_r;

    if (mode_r == swc_pkg::MODE_RUNNING) begin
      if (pre_inc < {1'b0, tph_r}) begin
        pre_nxt = pre_inc[swc_pkg::TICK_W-1:0];
      end else begin
        pre_nxt  = '0;
        hund_nxt = hund_inc[swc_pkg::HUND_W-1:0];
        if (hund_inc == {1'b0, beep_hund_r}) begin
          beep_nxt = 1'b0;
        end
        if (hund_inc >= swc_pkg::HUND_WRAP) begin
          hund_nxt = '0;
          beep_nxt = 1'b1;
          sec_nxt  = sec_inc[swc_pkg::SEC_W-1:0];
          if (sec_inc >= swc_pkg::SEC_WRAP) begin
            sec_nxt = '0;
            min_nxt = min_inc[swc_pkg::MIN_W-1:0];
            if (min_inc >= swc_pkg::MIN_WRAP) begin
              min_nxt  = '0;
              hour_nxt = hour_r + 1'b1;
            end
          end
        end
      end
    end

    if (ev != swc_pkg::EV_NONE) begin
      case (mode_r)
        swc_pkg::MODE_RUNNING: begin
          if (ev == swc_pkg::EV_SHORT) begin
            mode_nxt = swc_pkg::MODE_PAUSED;
          end
        end
        swc_pkg::MODE_PAUSED: begin
          if (ev == swc_pkg::EV_SHORT) begin
            mode_nxt = swc_pkg::MODE_RUNNING;
          end else begin
            mode_nxt = swc_pkg::MODE_STOPPED;
            pre_nxt  = '0;
            hund_nxt = '0;
            sec_nxt  = '0;
            min_nxt  = '0;
            hour_nxt = '0;
            beep_nxt = 1'b0;
          end
        end
        default: mode_nxt = swc_pkg::MODE_RUNNING;
      endcase
    end
  end

  // Stopwatch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= swc_pkg::MODE_STOPPED;
      pre_r  <= '0;
      hund_r <= '0;
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      beep_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pre_r  <= pre_nxt;
      hund_r <= hund_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      beep_r <= beep_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (accept) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_mode_r <= mode_nxt;
      res_hour_r <= hour_nxt;
      res_min_r  <= min_nxt;
      res_sec_r  <= sec_nxt;
      res_hund_r <= hund_nxt;
      res_beep_r <= beep_nxt;
      res_ev_r   <= ev;
    end
  end

  assign out_valid       = res_valid_r;
  assign out_mode        = res_mode_r;
  assign out_hours       = res_hour_r;
  assign out_minutes     = res_min_r;
  assign out_seconds     = res_sec_r;
  assign out_hundredths  = res_hund_r;
  assign out_beep_on     = res_beep_r;
  assign out_press_event = res_ev_r;

  // Digits stay in range
  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, hund_r} < swc_pkg::HUND_WRAP && {1'b0, sec_r} < swc_pkg::SEC_WRAP
      && {1'b0, min_r} < swc_pkg::MIN_WRAP)
    else $error("time digit out of range");

  // Time only moves while running or on a clear
  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && (mode_r == swc_pkg::MODE_RUNNING || ev == swc_pkg::EV_LONG))
      |=> $stable(hund_r) && $stable(sec_r) && $stable(pre_r))
    else $error("time moved while not running");

  // Long press while paused clears everything
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev == swc_pkg::EV_LONG && mode_r == swc_pkg::MODE_PAUSED
      |=> mode_r == swc_pkg::MODE_STOPPED && hund_r == '0 && sec_r == '0
        && min_r == '0 && hour_r == '0 && !beep_r)
    else $error("clear incomplete");

  // Input is held off only behind a full, stalled result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> res_valid_r)
    else $error("input stalled with empty result register");

endmodule

// ===== verif/stopwatch_controller_checker.sv =====
`timescale 1ns / 1ps

// Watches the tick and result channels plus the register port, keeps its own
// copy of the stopwatch state and compares every result transfer in order.
module stopwatch_controller_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_button_level,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [swc_pkg::MODE_W-1:0]    out_mode,
  input  logic [swc_pkg::HOUR_BITS-1:0] out_hours,
  input  logic [swc_pkg::MIN_W-1:0]     out_minutes,
  input  logic [swc_pkg::SEC_W-1:0]     out_seconds,
  input  logic [swc_pkg::HUND_W-1:0]    out_hundredths,
  input  logic                          out_beep_on,
  input  logic [swc_pkg::EV_W-1:0]      out_press_event,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [swc_pkg::APB_AW-1:0]    paddr,
  input  logic [swc_pkg::APB_DW-1:0]    pwdata,
  output int                            fail_count,
  output int                            pending
);

  typedef enum logic [2:0] {
    BTN_READY,
    BTN_DEB_PRESS,
    BTN_HOLD,
    BTN_HOLD_LONG,
    BTN_DEB_REL
  } btn_phase_t;

  typedef struct packed {
    logic [swc_pkg::MODE_W-1:0]    mode;
    logic [swc_pkg::HOUR_BITS-1:0] hours;
    logic [swc_pkg::MIN_W-1:0]     minutes;
    logic [swc_pkg::SEC_W-1:0]     seconds;
    logic [swc_pkg::HUND_W-1:0]    hundredths;
    logic                          beep_on;
    logic [swc_pkg::EV_W-1:0]      press_event;
  } tick_result_t;

  // register copies
  logic [swc_pkg::TICK_W-1:0]  ticks_per_hund;
  logic [swc_pkg::DEB_W-1:0]   debounce;
  logic [swc_pkg::TIMER_W-1:0] long_hold;
  logic [swc_pkg::HUND_W-1:0]  beep_hund;

  // stopwatch state copy
  btn_phase_t                    btn_phase;
  logic [swc_pkg::TIMER_W-1:0]   btn_timer;
  logic                          long_held;
  logic [swc_pkg::MODE_W-1:0]    sw_mode;
  logic [swc_pkg::TICK_W-1:0]    prescale;
  logic [swc_pkg::HUND_W-1:0]    hund;
  logic [swc_pkg::SEC_W-1:0]     secs;
  logic [swc_pkg::MIN_W-1:0]     mins;
  logic [swc_pkg::HOUR_BITS-1:0] hrs;
  logic                          beep;

  tick_result_t expected_results[$];
  tick_result_t want;
  int           results_seen;

  function automatic void clear_time();
    prescale = '0;
    hund     = '0;
    secs     = '0;
    mins     = '0;
    hrs      = '0;
    beep     = 1'b0;
  endfunction

  // One base tick: time counts with the mode held at the start of the tick,
  // then the classified press moves the mode.
  function automatic tick_result_t predict_tick(logic level);
    logic [swc_pkg::TICK_W:0]  next_presc;
    logic [swc_pkg::EV_W-1:0]  ev;
    tick_result_t              r;
    ev = swc_pkg::EV_NONE;

    // time base
    if (sw_mode == swc_pkg::MODE_RUNNING) begin
      next_presc = {1'b0, prescale} + 1'b1;
      if (next_presc < {1'b0, ticks_per_hund}) begin
        prescale = next_presc[swc_pkg::TICK_W-1:0];
      end else begin
        prescale = '0;
        hund = hund + 1'b1;
        // beep clear is checked before the wrap at 100
        if (hund == beep_hund) beep = 1'b0;
        if (hund >= swc_pkg::HUND_WRAP) begin
          hund = '0;
          beep = 1'b1;
          secs = secs + 1'b1;
          if (secs >= swc_pkg::SEC_WRAP) begin
            secs = '0;
            mins = mins + 1'b1;
            if (mins >= swc_pkg::MIN_WRAP) begin
              mins = '0;
              hrs  = hrs + 1'b1;
            end
          end
        end
      end
    end

    // press classifier
    case (btn_phase)
      BTN_READY: begin
        if (level) begin
          btn_timer = debounce;
          btn_phase = BTN_DEB_PRESS;
        end
      end
      BTN_DEB_PRESS: begin
        if (btn_timer == '0) begin
          btn_timer = long_hold;
          btn_phase = BTN_HOLD;
        end else begin
          btn_timer = btn_timer - 1'b1;
        end
      end
      BTN_HOLD: begin
        if (!level) begin
          btn_timer = debounce;
          btn_phase = BTN_DEB_REL;
        end else if (btn_timer != '0) begin
          btn_timer = btn_timer - 1'b1;
        end else begin
          btn_phase = BTN_HOLD_LONG;
        end
      end
      BTN_HOLD_LONG: begin
        if (!level) begin
          long_held = 1'b1;
          btn_timer = debounce;
          btn_phase = BTN_DEB_REL;
        end
      end
      BTN_DEB_REL: begin
        if (btn_timer == '0) begin
          ev        = long_held ? swc_pkg::EV_LONG : swc_pkg::EV_SHORT;
          long_held = 1'b0;
          btn_phase = BTN_READY;
        end else begin
          btn_timer = btn_timer - 1'b1;
        end
      end
      default: begin
        btn_phase = BTN_READY;
        btn_timer = '0;
      end
    endcase

    // mode reaction
    if (ev != swc_pkg::EV_NONE) begin
      if (sw_mode == swc_pkg::MODE_RUNNING) begin
        if (ev == swc_pkg::EV_SHORT) sw_mode = swc_pkg::MODE_PAUSED;
      end else if (sw_mode == swc_pkg::MODE_PAUSED) begin
        if (ev == swc_pkg::EV_SHORT) begin
          sw_mode = swc_pkg::MODE_RUNNING;
        end else begin
          clear_time();
          sw_mode = swc_pkg::MODE_STOPPED;
        end
      end else begin
        sw_mode = swc_pkg::MODE_RUNNING;
      end
    end

    r.mode        = sw_mode;
    r.hours       = hrs;
    r.minutes     = mins;
    r.seconds     = secs;
    r.hundredths  = hund;
    r.beep_on     = beep;
    r.press_event = ev;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d: %s = %0d, expected %0d",
                                results_seen, name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_hund = swc_pkg::RST_TICKS_PER_HUND;
      debounce       = swc_pkg::RST_DEBOUNCE;
      long_hold      = swc_pkg::RST_LONG_HOLD;
      beep_hund      = swc_pkg::RST_BEEP_HUND;
      btn_phase      = BTN_READY;
      btn_timer      = '0;
      long_held      = 1'b0;
      sw_mode        = swc_pkg::MODE_STOPPED;
      clear_time();
      expected_results.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          swc_pkg::REG_TICKS_PER_HUND: ticks_per_hund = pwdata[swc_pkg::TICK_W-1:0];
          swc_pkg::REG_DEBOUNCE:       debounce       = pwdata[swc_pkg::DEB_W-1:0];
          swc_pkg::REG_LONG_HOLD:      long_hold      = pwdata[swc_pkg::TIMER_W-1:0];
          swc_pkg::REG_BEEP_HUND:      beep_hund      = pwdata[swc_pkg::HUND_W-1:0];
          default: ;
        endcase
      end

      // result transfer: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no tick waiting",
                                    results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("mode",        16'(out_mode),        16'(want.mode));
          check_field("hours",       16'(out_hours),       16'(want.hours));
          check_field("minutes",     16'(out_minutes),     16'(want.minutes));
          check_field("seconds",     16'(out_seconds),     16'(want.seconds));
          check_field("hundredths",  16'(out_hundredths),  16'(want.hundredths));
          check_field("beep_on",     16'(out_beep_on),     16'(want.beep_on));
          check_field("press_event", 16'(out_press_event), 16'(want.press_event));
        end
        results_seen++;
      end

      // tick transfer: its result can only show up on a later edge
      if (in_valid && !in_stall)
        expected_results.push_back(predict_tick(in_button_level));
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/stopwatch_controller_core_test.sv =====
`timescale 1ns / 1ps

module stopwatch_controller_core_test;

  localparam int LIMIT_CYCLES    = 2_000_000;
  localparam int HOLD_OFF_CYCLES = 50;
  // longest press or release shaped by the random part
  localparam int MAX_PRESS       = 40;
  // base ticks per chunk of the closing run
  localparam int LONG_RUN_CHUNK  = 60;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_button_level;
  logic                          out_valid;
  logic                          out_stall;
  logic [swc_pkg::MODE_W-1:0]    out_mode;
  logic [swc_pkg::HOUR_BITS-1:0] out_hours;
  logic [swc_pkg::MIN_W-1:0]     out_minutes;
  logic [swc_pkg::SEC_W-1:0]     out_seconds;
  logic [swc_pkg::HUND_W-1:0]    out_hundredths;
  logic                          out_beep_on;
  logic [swc_pkg::EV_W-1:0]      out_press_event;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [swc_pkg::APB_AW-1:0]    paddr;
  logic [swc_pkg::APB_DW-1:0]    pwdata;
  logic [swc_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  int fail_count;
  int pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;
  // current debounce and hold settings, used to shape presses
  int cur_deb;
  int cur_long;

  stopwatch_controller_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mode        (out_mode),
    .out_hours       (out_hours),
    .out_minutes     (out_minutes),
    .out_seconds     (out_seconds),
    .out_hundredths  (out_hundredths),
    .out_beep_on     (out_beep_on),
    .out_press_event (out_press_event),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  stopwatch_controller_checker score (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mode        (out_mode),
    .out_hours       (out_hours),
    .out_minutes     (out_minutes),
    .out_seconds     (out_seconds),
    .out_hundredths  (out_hundredths),
    .out_beep_on     (out_beep_on),
    .out_press_event (out_press_event),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // All driving tasks start and end at a falling edge with nothing yet
  // assigned in that time step.
  task automatic send_tick(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_tick(level);
  endtask

  task automatic send_press(input int high_ticks, input int low_ticks);
    send_run(1'b1, high_ticks);
    send_run(1'b0, low_ticks);
  endtask

  // stop offering ticks until every result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // upper data bits carry random junk that the registers must drop
  task automatic program_regs(input int tph, input int deb, input int lhold,
                              input int beep_at);
    logic [31:0] junk;
    drain();
    junk = $urandom();
    write_reg(swc_pkg::REG_TICKS_PER_HUND, {junk[31:8], tph[7:0]});
    junk = $urandom();
    write_reg(swc_pkg::REG_DEBOUNCE, {junk[31:8], deb[7:0]});
    junk = $urandom();
    write_reg(swc_pkg::REG_LONG_HOLD, {junk[31:16], lhold[15:0]});
    junk = $urandom();
    write_reg(swc_pkg::REG_BEEP_HUND, {junk[31:7], beep_at[6:0]});
    cur_deb  = deb;
    cur_long = lhold;
  endtask

  // Mostly whole presses around the short/long threshold, some noise.
  // pause_at >= 0 makes the sender wait for all results once mid-way.
  task automatic random_ticks(input int count, input int pause_at);
    int sent;
    int thr;
    int gap;
    int hold_len;
    int rel_len;
    int stop_at;
    sent    = 0;
    stop_at = pause_at;
    while (sent < count) begin
      thr = cur_deb + cur_long + 2;
      if ($urandom_range(99) < 20) begin
        gap = $urandom_range(1, 6);
        repeat (gap) send_tick(1'($urandom_range(1)));
        sent += gap;
      end else begin
        gap = $urandom_range(0, 3);
        if ($urandom_range(1)) hold_len = $urandom_range(thr + 1, thr + 4);
        else hold_len = $urandom_range(1, thr);
        // huge debounce or hold settings only get partial presses
        if (hold_len > MAX_PRESS) hold_len = $urandom_range(1, MAX_PRESS);
        rel_len = cur_deb + $urandom_range(1, 3);
        if (rel_len > MAX_PRESS) rel_len = MAX_PRESS;
        send_run(1'b0, gap);
        send_press(hold_len, rel_len);
        sent += gap + hold_len + rel_len;
      end
      if (stop_at >= 0 && sent >= stop_at) begin
        drain();
        stop_at = -1;
      end
    end
  endtask

  initial begin
    int tph;
    int deb;
    int lhold;
    int beep_at;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_button_level = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    hold_off_req    = 1'b0;
    send_idle_pct   = 29;
    recv_idle_pct   = 64;
    cur_deb         = swc_pkg::RST_DEBOUNCE;
    cur_long        = swc_pkg::RST_LONG_HOLD;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: with no debounce and no hold, a short press is two high and
    // two low ticks, a long press three high and two low.
    program_regs(1, 0, 0, 1);
    send_press(2, 2);   // stopped: start
    send_press(3, 2);   // running: long press ignored
    send_press(2, 2);   // running: pause
    send_press(2, 2);   // paused: resume
    send_press(2, 2);   // running: pause
    send_press(3, 2);   // paused: long press clears and stops

    // Random part in nine settings, idling shifts every third one
    for (int sp = 0; sp < 9; sp++) begin
      if (sp == 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 29;
      end
      if (sp == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (sp)
        0: program_regs(1, 0, 0, 0);
        1: program_regs(255, 0, 4, 100);
        // also lowers the prescale target below a count that may be running
        2: program_regs(3, 255, 65535, 127);
        default: begin
          tph   = $urandom_range(0, 3);
          deb   = $urandom_range(0, 3);
          lhold = $urandom_range(0, 10);
          case ($urandom_range(4))
            0: beep_at = 0;
            1: beep_at = 1;
            2: beep_at = 100;
            3: beep_at = 127;
            default: beep_at = $urandom_range(1, 99);
          endcase
          program_regs(tph, deb, lhold, beep_at);
        end
      endcase
      if (sp == 1 || sp == 7) hold_off_req = 1'b1;
      random_ticks((sp == 2) ? 60 : 120, (sp == 0 || sp == 4) ? 70 : -1);
    end

    // Closing run: one hundredth per tick across the beep clear settings. A
    // low stretch settles the button, then two long presses leave it running
    // from any mode.
    program_regs(0, 1, 3, 50);
    send_run(1'b0, 20);
    send_press(9, 4);
    send_press(9, 4);
    send_run(1'b0, LONG_RUN_CHUNK);
    program_regs(0, 1, 3, 100);
    send_run(1'b0, LONG_RUN_CHUNK);
    program_regs(0, 1, 3, 0);
    send_run(1'b0, LONG_RUN_CHUNK);
    program_regs(0, 1, 3, 127);
    send_run(1'b0, LONG_RUN_CHUNK);

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
